>>> rtl/ahhc_pkg.sv
`default_nettype none
package ahhc_pkg;

  // Ring depth default and fixed field widths
  localparam int unsigned WINDOW_DEF = 100;
  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned BAND_W     = 15;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned HOLDOFF_W  = 4;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [HOLDOFF_W-1:0] HOLDOFF   = 4'd10;
  localparam logic [PCT_W-1:0]     PCT_MAX   = 7'd100;
  localparam logic [PCT_W-1:0]     PHASE_MAX = 7'd100;
  localparam logic [PCT_W-1:0]     PHASE_RST = 7'd1;
  localparam logic [PCT_W-1:0]     POWER_RST = 7'd50;

  localparam logic signed [SAMPLE_W-1:0] TARGET_RST = 16'sd8960;
  localparam logic [BAND_W-1:0]          BAND_RST   = 15'd128;
  localparam logic [PCT_W-1:0]           HEAT_RST   = 7'd50;
  localparam logic [PCT_W-1:0]           HOLD_RST   = 7'd50;
  localparam logic [PCT_W-1:0]           STEP_RST   = 7'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET    = 3'd0,
    CFG_BAND      = 3'd1,
    CFG_HEAT      = 3'd2,
    CFG_HOLD_INIT = 3'd3,
    CFG_STEP      = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_UNKNOWN = 2'd0,
    MODE_HEATING = 2'd1,
    MODE_HOLDING = 2'd2,
    MODE_COOLING = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_START,
    ST_DIVIDE,
    ST_COMMIT
  } ctrl_state_e;

  // Controller to datapath
  typedef struct packed {
    logic load;       // take item, read old slot
    logic update;     // replace slot, adjust sum and count
    logic div_start;  // launch mean division
    logic commit;     // mode update, load result
  } ctrl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic cnt_zero;
    logic div_done;
    logic out_free;
  } ctrl_sts_t;

endpackage : ahhc_pkg
`default_nettype wire

>>> rtl/ahhc_div.sv
`default_nettype none
module ahhc_div #(
  parameter int unsigned DVD_W = 23,
  parameter int unsigned DVS_W = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W-1:0] dvs_q;
  logic [DVS_W:0]   rem_q, rem_d, rem_sh;
  logic [DVD_W-1:0] quot_q, quot_d;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic             q_bit;

  // One quotient bit per cycle, restoring
  always_comb begin
    rem_sh = {rem_q[DVS_W-1:0], quot_q[DVD_W-1]};
    q_bit  = (rem_sh >= {1'b0, dvs_q});
    rem_d  = q_bit ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
    quot_d = {quot_q[DVD_W-2:0], q_bit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvs_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= dividend_i;
    end else if (busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule : ahhc_div
`default_nettype wire

>>> rtl/ahhc_ctrl.sv
`default_nettype none
module ahhc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire ahhc_pkg::ctrl_sts_t sts_i,
  output ahhc_pkg::ctrl_cmd_t      cmd_o
);
  import ahhc_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.update = 1'b1;
        state_d      = ST_START;
      end
      ST_START: begin
        // empty ring: mean is zero, skip the divide
        if (sts_i.cnt_zero) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (sts_i.div_done) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule : ahhc_ctrl
`default_nettype wire

>>> rtl/ahhc_dp.sv
`default_nettype none
module ahhc_dp #(
  parameter int unsigned WINDOW = ahhc_pkg::WINDOW_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  input  wire logic                                       cfg_we_i,
  input  wire logic [ahhc_pkg::CFG_IDX_W-1:0]             cfg_idx_i,
  input  wire logic [ahhc_pkg::CFG_DATA_W-1:0]            cfg_data_i,
  input  wire logic signed [ahhc_pkg::SAMPLE_W-1:0]       sample_i,
  input  wire ahhc_pkg::ctrl_cmd_t                        cmd_i,
  output ahhc_pkg::ctrl_sts_t                             sts_o,
  input  wire logic                                       out_ready_i,
  output logic                                            out_valid_o,
  output logic                                            heater_on_o,
  output logic [1:0]                                      mode_o,
  output logic [ahhc_pkg::PCT_W-1:0]                      power_o,
  output logic [ahhc_pkg::PCT_W-1:0]                      hold_level_o,
  output logic signed [ahhc_pkg::SAMPLE_W-1:0]            mean_temp_o
);
  import ahhc_pkg::*;

  localparam int unsigned PTR_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned SUM_W = SAMPLE_W + CNT_W;

  // Configuration
  logic signed [SAMPLE_W-1:0] target_q;
  logic [BAND_W-1:0]          band_q;
  logic [PCT_W-1:0]           heat_q, step_q;

  // Ring and running statistics
  logic signed [SAMPLE_W-1:0] ring_q [WINDOW];
  logic [WINDOW-1:0]          vld_q;
  logic [PTR_W-1:0]           pos_q;
  logic signed [SAMPLE_W-1:0] sample_q, rd_data_q;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]           cnt_q, cnt_d;
  logic                       old_nz, new_nz;

  // Control loop state
  mode_e                mode_q, mode_d;
  logic [PCT_W-1:0]     power_q, power_d;
  logic [PCT_W-1:0]     hold_q, hold_d;
  logic [HOLDOFF_W-1:0] holdoff_q, holdoff_d, holdoff_set;
  logic [PCT_W-1:0]     phase_q, phase_d;
  logic                 on_q, on_d;
  logic signed [SAMPLE_W-1:0] mean_q;
  logic                 out_valid_q;

  // Mean and compare
  logic [SUM_W-1:0]           mag;
  logic [SUM_W-1:0]           quot, mean_full;
  logic                       div_done;
  logic signed [SAMPLE_W-1:0] mean;
  logic signed [SAMPLE_W:0]   delta, band_p, band_n;
  logic                       below, above;
  logic [PCT_W-1:0]           heat_sat;
  logic [PCT_W:0]             hold_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TARGET_RST;
      band_q   <= BAND_RST;
      heat_q   <= HEAT_RST;
      step_q   <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_TARGET: target_q <= cfg_data_i;
        CFG_BAND:   band_q   <= cfg_data_i[BAND_W-1:0];
        CFG_HEAT:   heat_q   <= cfg_data_i[PCT_W-1:0];
        CFG_STEP:   step_q   <= cfg_data_i[PCT_W-1:0];
        default: ;
      endcase
    end
  end

  // Ring memory: read old slot on load, write new sample on update
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q  <= sample_i;
      rd_data_q <= ring_q[pos_q];
    end
    if (cmd_i.update) begin
      ring_q[pos_q] <= sample_q;
    end
  end

  assign old_nz = vld_q[pos_q] && (rd_data_q != '0);
  assign new_nz = (sample_q != '0);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (old_nz) begin
      sum_d = sum_d - {{(SUM_W-SAMPLE_W){rd_data_q[SAMPLE_W-1]}}, rd_data_q};
      cnt_d = cnt_d - 1'b1;
    end
    if (new_nz) begin
      sum_d = sum_d + {{(SUM_W-SAMPLE_W){sample_q[SAMPLE_W-1]}}, sample_q};
      cnt_d = cnt_d + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      pos_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.update) begin
      vld_q[pos_q] <= 1'b1;
      pos_q <= (pos_q == PTR_W'(WINDOW - 1)) ? '0 : pos_q + 1'b1;
      sum_q <= sum_d;
      cnt_q <= cnt_d;
    end
  end

  // Divide magnitude, restore sign: truncation toward zero
  assign mag = sum_q[SUM_W-1] ? (-sum_q) : sum_q;

  ahhc_div #(
    .DVD_W(SUM_W),
    .DVS_W(CNT_W)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (cmd_i.div_start),
    .dividend_i(mag),
    .divisor_i (cnt_q),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  assign mean_full = sum_q[SUM_W-1] ? (-quot) : quot;
  assign mean      = (cnt_q == '0) ? '0 : mean_full[SAMPLE_W-1:0];

  assign delta  = {target_q[SAMPLE_W-1], target_q} - {mean[SAMPLE_W-1], mean};
  assign band_p = {2'b00, band_q};
  assign band_n = -band_p;
  assign below  = (delta < band_n);
  assign above  = (delta > band_p);

  assign heat_sat = (heat_q > PCT_MAX) ? PCT_MAX : heat_q;
  assign hold_sum = {1'b0, hold_q} + {1'b0, step_q};

  always_comb begin
    mode_d      = mode_q;
    power_d     = power_q;
    hold_d      = hold_q;
    holdoff_set = holdoff_q;
    unique case (mode_q)
      MODE_UNKNOWN: begin
        if (below) begin
          mode_d  = MODE_COOLING;
          power_d = '0;
        end else if (above) begin
          mode_d  = MODE_HEATING;
          power_d = heat_sat;
        end else if ((delta < band_p) && (delta > band_n)) begin
          mode_d  = MODE_HOLDING;
          power_d = hold_q;
        end
      end
      MODE_HEATING: begin
        if (delta < band_p) begin
          mode_d  = MODE_HOLDING;
          power_d = hold_q;
        end
      end
      MODE_HOLDING: begin
        if (below) begin
          mode_d  = MODE_COOLING;
          power_d = '0;
          // back off hold power, rate-limited by holdoff
          if (holdoff_q == '0) begin
            hold_d      = (hold_q > step_q) ? (hold_q - step_q) : '0;
            holdoff_set = HOLDOFF;
          end
        end else if (above) begin
          mode_d  = MODE_HEATING;
          hold_d  = (hold_sum > {1'b0, PCT_MAX}) ? PCT_MAX : hold_sum[PCT_W-1:0];
          power_d = heat_sat;
        end
      end
      MODE_COOLING: begin
        if (delta > band_n) begin
          mode_d  = MODE_HOLDING;
          power_d = hold_q;
        end
      end
      default: mode_d = MODE_UNKNOWN;
    endcase
    on_d      = (power_d > phase_q);
    phase_d   = (phase_q >= PHASE_MAX) ? '0 : phase_q + 1'b1;
    holdoff_d = (holdoff_set != '0) ? holdoff_set - 1'b1 : holdoff_set;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_UNKNOWN;
      power_q   <= POWER_RST;
      hold_q    <= HOLD_RST;
      holdoff_q <= '0;
      phase_q   <= PHASE_RST;
    end else if (cfg_we_i && (cfg_idx_i == CFG_HOLD_INIT)) begin
      hold_q <= (cfg_data_i[PCT_W-1:0] > PCT_MAX) ? PCT_MAX : cfg_data_i[PCT_W-1:0];
    end else if (cmd_i.commit) begin
      mode_q    <= mode_d;
      power_q   <= power_d;
      hold_q    <= hold_d;
      holdoff_q <= holdoff_d;
      phase_q   <= phase_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      on_q   <= on_d;
      mean_q <= mean;
    end
  end

  assign sts_o.cnt_zero = (cnt_q == '0);
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o  = out_valid_q;
  assign heater_on_o  = on_q;
  assign mode_o       = mode_q;
  assign power_o      = power_q;
  assign hold_level_o = hold_q;
  assign mean_temp_o  = mean_q;

endmodule : ahhc_dp
`default_nettype wire

>>> rtl/adaptive_hysteresis_heater_control.sv
`default_nettype none
// Channel   Dir  Handshake                      Payload
// s_axis    in   s_axis_tvalid_i/tready_o       sample
// m_axis    out  m_axis_tvalid_o/tready_i       heater_on, mode, power, hold_level, mean_temp
// cfg       in   cfg_we_i (no wait)             cfg_idx_i selects register, cfg_data_i
//
// ST_IDLE takes an item and reads its old ring slot, ST_READ replaces the slot and updates
// sum and count, ST_START launches the divide for the mean, ST_DIVIDE waits for it, and
// ST_COMMIT loads the result. The divider is bit-serial (one quotient bit per cycle over
// 16 + clog2(WINDOW + 1) bits). An empty ring skips the divide. Items are handled one at
// a time. Reset clears the ring through per-slot valid bits; no clearing pass is needed.
// A held result stalls the final commit, and no new item is taken until it commits.
module adaptive_hysteresis_heater_control #(
  parameter int unsigned WINDOW = ahhc_pkg::WINDOW_DEF
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  s_axis_tvalid_i,
  output logic                                       s_axis_tready_o,
  input  wire logic [ahhc_pkg::SAMPLE_W-1:0]         s_axis_tdata_i,  // [15:0] sample
  output logic                                       m_axis_tvalid_o,
  input  wire logic                                  m_axis_tready_i,
  // [0] heater_on, [2:1] mode, [9:3] power, [16:10] hold_level, [32:17] mean_temp
  output logic [ahhc_pkg::OUT_DATA_W-1:0]            m_axis_tdata_o,
  input  wire logic                                  cfg_we_i,
  input  wire logic [ahhc_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  wire logic [ahhc_pkg::CFG_DATA_W-1:0]       cfg_data_i
);
  import ahhc_pkg::*;

  ctrl_cmd_t               cmd;
  ctrl_sts_t               sts;
  logic                    heater_on;
  logic [1:0]              mode;
  logic [PCT_W-1:0]        power, hold_level;
  logic signed [SAMPLE_W-1:0] mean_temp;

  ahhc_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ahhc_dp #(
    .WINDOW(WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .sample_i    (s_axis_tdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .heater_on_o (heater_on),
    .mode_o      (mode),
    .power_o     (power),
    .hold_level_o(hold_level),
    .mean_temp_o (mean_temp)
  );

  assign m_axis_tdata_o = {7'b0, mean_temp, hold_level, power, mode, heater_on};

endmodule : adaptive_hysteresis_heater_control
`default_nettype wire

>>> tb/adaptive_hysteresis_heater_control_checker.sv
`timescale 1ns / 100ps
module adaptive_hysteresis_heater_control_checker
  import ahhc_pkg::*;
#(
  parameter int unsigned WINDOW = WINDOW_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [SAMPLE_W-1:0]   s_axis_tdata_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    errors_o,
  output int                    pending_o
);

  localparam int PCT_TOP   = int'(PCT_MAX);
  localparam int PHASE_TOP = int'(PHASE_MAX);

  // Field order of the result bus, lowest bit last
  typedef struct packed {
    logic [SAMPLE_W-1:0] mean;
    logic [PCT_W-1:0]    hold;
    logic [PCT_W-1:0]    power;
    mode_e               mode;
    logic                heater;
  } heater_status_t;

  // Controller settings
  int target_q;
  int band_q;
  int heat_q;
  int step_q;

  // Controller state
  logic signed [SAMPLE_W-1:0] ring [WINDOW];
  int    wr_pos;
  int    live_cnt;
  int    running_sum;
  mode_e mode_q;
  int    power_q;
  int    hold_q;
  int    holdoff;
  int    phase;

  heater_status_t expected_status_q[$];
  int             mismatch_cnt;

  function automatic int clip_pct(int v);
    return (v > PCT_TOP) ? PCT_TOP : v;
  endfunction

  function automatic heater_status_t step_controller(logic signed [SAMPLE_W-1:0] smp);
    heater_status_t r;
    int mean_v;
    int delta;
    int heat_sat;
    heat_sat = clip_pct(heat_q);
    if (ring[wr_pos] != 0) begin
      running_sum -= int'(ring[wr_pos]);
      live_cnt--;
    end
    if (smp != 0) begin
      running_sum += int'(smp);
      live_cnt++;
    end
    ring[wr_pos] = smp;
    wr_pos = (wr_pos + 1 >= int'(WINDOW)) ? 0 : wr_pos + 1;
    mean_v = (live_cnt != 0) ? running_sum / live_cnt : 0;
    delta = target_q - mean_v;

    case (mode_q)
      MODE_UNKNOWN: begin
        if (delta < -band_q) begin
          mode_q = MODE_COOLING;
          power_q = 0;
        end else if (delta > band_q) begin
          mode_q = MODE_HEATING;
          power_q = heat_sat;
        end else if (delta < band_q && delta > -band_q) begin
          mode_q = MODE_HOLDING;
          power_q = hold_q;
        end
      end
      MODE_HEATING: begin
        if (delta < band_q) begin
          mode_q = MODE_HOLDING;
          power_q = hold_q;
        end
      end
      MODE_HOLDING: begin
        if (delta < -band_q) begin
          mode_q = MODE_COOLING;
          // lower the hold level only once the holdoff has run out
          if (holdoff == 0) begin
            hold_q = (hold_q > step_q) ? hold_q - step_q : 0;
            holdoff = int'(HOLDOFF);
          end
          power_q = 0;
        end else if (delta > band_q) begin
          mode_q = MODE_HEATING;
          hold_q = clip_pct(hold_q + step_q);
          power_q = heat_sat;
        end
      end
      default: begin
        if (delta > -band_q) begin
          mode_q = MODE_HOLDING;
          power_q = hold_q;
        end
      end
    endcase

    r.heater = (power_q > phase);
    r.mode   = mode_q;
    r.power  = PCT_W'(power_q);
    r.hold   = PCT_W'(hold_q);
    r.mean   = SAMPLE_W'(mean_v);

    phase = (phase >= PHASE_TOP) ? 0 : phase + 1;
    if (holdoff > 0) holdoff--;
    return r;
  endfunction

  task automatic write_setting(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_TARGET:    target_q = int'($signed(data[SAMPLE_W-1:0]));
      CFG_BAND:      band_q = int'(data[BAND_W-1:0]);
      CFG_HEAT:      heat_q = int'(data[PCT_W-1:0]);
      CFG_HOLD_INIT: hold_q = clip_pct(int'(data[PCT_W-1:0]));
      CFG_STEP:      step_q = int'(data[PCT_W-1:0]);
      default: ;
    endcase
  endtask

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    heater_status_t got;
    heater_status_t want;
    if (!rst_ni) begin
      target_q = int'(TARGET_RST);
      band_q = int'(BAND_RST);
      heat_q = int'(HEAT_RST);
      step_q = int'(STEP_RST);
      foreach (ring[k]) ring[k] = '0;
      wr_pos = 0;
      live_cnt = 0;
      running_sum = 0;
      mode_q = MODE_UNKNOWN;
      power_q = int'(POWER_RST);
      hold_q = int'(HOLD_RST);
      holdoff = 0;
      phase = int'(PHASE_RST);
      expected_status_q.delete();
      mismatch_cnt = 0;
      errors_o <= 0;
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = heater_status_t'(m_axis_tdata_i[$bits(heater_status_t)-1:0]);
        if (expected_status_q.size() == 0) begin
          $display("%0t: result with nothing expected, expected none got %h",
                   $time, m_axis_tdata_i);
          mismatch_cnt++;
        end else begin
          want = expected_status_q.pop_front();
          check_field("heater_on", int'(want.heater), int'(got.heater));
          check_field("mode", int'(want.mode), int'(got.mode));
          check_field("power", int'(want.power), int'(got.power));
          check_field("hold_level", int'(want.hold), int'(got.hold));
          check_field("mean_temp", int'($signed(want.mean)), int'($signed(got.mean)));
        end
      end
      if (cfg_we_i) write_setting(cfg_idx_i, cfg_data_i);
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_status_q.push_back(step_controller(s_axis_tdata_i));
      end
      errors_o <= mismatch_cnt;
      pending_o <= expected_status_q.size();
    end
  end

endmodule

>>> tb/adaptive_hysteresis_heater_control_tb.sv
`timescale 1ns / 100ps
module adaptive_hysteresis_heater_control_tb;
  import ahhc_pkg::*;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 6;
  localparam int PHASE_ITEMS   = 105;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [SAMPLE_W-1:0]   s_axis_tdata = '0;   // [15:0] sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // [0] heater_on, [2:1] mode, [9:3] power, [16:10] hold_level, [32:17] mean_temp
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int error_cnt;
  int pending_cnt;
  int idle_pct = 0;
  int ready_hold = 0;
  int cycle_cnt = 0;

  // Current target and band, used to steer the samples
  int target_now = int'(TARGET_RST);
  int band_now = int'(BAND_RST);
  int swing = 0;
  int swing_dir = 1;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  adaptive_hysteresis_heater_control u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data)
  );

  adaptive_hysteresis_heater_control_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_i (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .m_axis_tvalid_i (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_i  (m_axis_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .errors_o        (error_cnt),
    .pending_o       (pending_cnt)
  );

  // Result side: at random, with chance idle_pct, drop ready for a burst of random length
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      m_axis_tready <= 1'b0;
      ready_hold <= $urandom_range(0, 7);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[adaptive_hysteresis_heater_control] ERROR");
      $finish;
    end
  end

  task automatic feed_sample(logic [SAMPLE_W-1:0] smp);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= smp;
    do @(posedge clk_i); while (!s_axis_tready);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  endtask

  // Drop valid and hold until every item has come back
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_cnt != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk_i);
  endtask

  task automatic set_controller(logic [CFG_DATA_W-1:0] target, logic [CFG_DATA_W-1:0] band,
                                logic [CFG_DATA_W-1:0] heat, logic [CFG_DATA_W-1:0] hold_init,
                                logic [CFG_DATA_W-1:0] step);
    // an index past the register list must be ignored
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_IDX_W'(int'(CFG_STEP) + $urandom_range(1, 3)), CFG_DATA_W'($urandom));
    end
    write_reg(CFG_TARGET, target);
    write_reg(CFG_BAND, band);
    write_reg(CFG_HEAT, heat);
    write_reg(CFG_HOLD_INIT, hold_init);
    write_reg(CFG_STEP, step);
    cfg_we <= 1'b0;
    @(posedge clk_i);
    target_now = int'($signed(target));
    band_now = int'(band[BAND_W-1:0]);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_pct();
    return ($urandom_range(0, 4) == 0) ? CFG_DATA_W'($urandom)
                                       : CFG_DATA_W'($urandom_range(0, 127));
  endfunction

  task automatic random_settings();
    logic [CFG_DATA_W-1:0] target;
    logic [CFG_DATA_W-1:0] band;
    target = ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                         : CFG_DATA_W'($urandom_range(0, 16000) - 8000);
    case ($urandom_range(0, 2))
      0:       band = '0;
      1:       band = CFG_DATA_W'($urandom_range(1, 600));
      default: band = CFG_DATA_W'($urandom);
    endcase
    set_controller(target, band, pick_pct(), pick_pct(), pick_pct());
  endtask

  // Temperature that drifts slowly above and below the target, so that the
  // windowed mean crosses the band; mixed with empty and wild readings
  task automatic drift_samples(int count);
    int amp;
    int roll;
    int val;
    amp = band_now * 4 + 512;
    if (amp > 24000) amp = 24000;
    if (swing > amp) swing = amp;
    if (swing < -amp) swing = -amp;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 8) begin
        val = 0;
      end else if (roll < 13) begin
        val = int'($signed(SAMPLE_W'($urandom)));
      end else begin
        swing += swing_dir * int'($urandom_range(0, amp / 20 + 1));
        if (swing > amp) swing_dir = -1;
        else if (swing < -amp) swing_dir = 1;
        val = target_now + swing;
        if (val > 32767) val = 32767;
        if (val < -32768) val = -32768;
      end
      feed_sample(SAMPLE_W'(val));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: means exactly on the band edges keep the mode unknown
    feed_sample(16'd8832);
    feed_sample(16'd0);
    feed_sample(16'd9344);
    feed_sample(16'd9000);
    feed_sample(16'h7FFF);
    feed_sample(16'h8000);
    feed_sample(16'h8000);
    feed_sample(16'hFFFF);
    feed_sample(16'h0001);
    settle();

    // Top target, zero band, heat and hold percents above 100
    set_controller(16'h7FFF, 16'h0000, 16'h007F, 16'h007F, 16'd100);
    feed_sample(16'h7FFF);
    feed_sample(16'h7FFF);
    feed_sample(16'h8000);
    feed_sample(16'h7FFF);
    feed_sample(16'h5555);
    settle();

    // Bottom target, widest band, zero percents
    set_controller(16'h8000, 16'hFFFF, 16'h0000, 16'h0000, 16'h0000);
    feed_sample(16'h8000);
    feed_sample(16'h7FFF);
    feed_sample(16'hAAAA);
    feed_sample(16'h8000);
    feed_sample(16'h0100);
    settle();

    // Large steps drive the hold level into both limits
    set_controller(16'h0000, 16'h0001, 16'd100, 16'd100, 16'd127);
    feed_sample(16'h7FFF);
    feed_sample(16'h8000);
    feed_sample(16'h8000);
    feed_sample(16'h7FFF);
    feed_sample(16'h7FFF);
    feed_sample(16'h0000);
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      idle_pct = (ph == PHASES - 1) ? 0 : 10 * int'($urandom_range(0, 4));
      random_settings();
      drift_samples(PHASE_ITEMS);
      // a long run of empty readings clears the ring
      if (ph == 2) begin
        repeat (WINDOW_DEF + 5) feed_sample('0);
      end
      settle();
    end

    if (error_cnt == 0 && pending_cnt == 0) begin
      $display("[adaptive_hysteresis_heater_control] OK");
    end else begin
      $display("[adaptive_hysteresis_heater_control] ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/ahhc_pkg.sv
rtl/ahhc_div.sv
rtl/ahhc_ctrl.sv
rtl/ahhc_dp.sv
rtl/adaptive_hysteresis_heater_control.sv
tb/adaptive_hysteresis_heater_control_checker.sv
tb/adaptive_hysteresis_heater_control_tb.sv
